@@ src/rne_pkg.sv @@
package rne_pkg;

   // Year and bound width
   localparam int YEAR_W = 12;

   // Largest year that has a numeral with at most three M letters
   localparam logic [YEAR_W-1:0] YEAR_CAP = 12'd3999;

   // Bound register reset values
   localparam logic [YEAR_W-1:0] LOWEST_RESET  = 12'd1000;
   localparam logic [YEAR_W-1:0] HIGHEST_RESET = 12'd3000;

   // Register indexes on the csr port
   localparam logic CSR_LOWEST  = 1'b0;
   localparam logic CSR_HIGHEST = 1'b1;

   // One classified year: range flag and decimal digits
   typedef struct packed {
      logic       err;
      logic [1:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
   } entry_type;

endpackage

@@ src/rne_front.sv @@
module rne_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [11:0]             req_year,
   input  logic [11:0]             lowest_year,
   input  logic [11:0]             highest_year,
   output logic                    push,
   output rne_pkg::entry_type      push_data,
   input  logic                    q_full
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HUND = 2'd1;
   localparam logic [1:0] S_TENS = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [11:0] rem_ff, rem_in;
   logic        err_ff, err_in;
   logic [1:0]  thou_ff, thou_in;
   logic [3:0]  hund_ff, hund_in;
   logic [3:0]  tens_ff, tens_in;
   logic [3:0]  ones_ff, ones_in;

   logic [11:0] lo_eff;
   logic [11:0] hi_eff;
   logic [3:0]  dig;

   // Count how many whole units fit into the remainder (at most nine)
   function automatic logic [3:0] digit_of(input logic [11:0] rem, input logic [11:0] unit);
      logic [3:0] d;
      d = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if ({4'd0, rem} >= 16'(k) * {4'd0, unit}) begin
            d = 4'(k);
         end
      end
      return d;
   endfunction

   // Value of a digit in the given place
   function automatic logic [11:0] scale(input logic [3:0] d, input logic [11:0] unit);
      return 12'({8'd0, d} * unit);
   endfunction

   // Clamp the configured bounds
   assign lo_eff = (lowest_year == 12'd0) ? 12'd1 : lowest_year;
   assign hi_eff = (highest_year > rne_pkg::YEAR_CAP) ? rne_pkg::YEAR_CAP : highest_year;

   assign req_stall = (state_ff != S_IDLE);
   assign push      = (state_ff == S_PUSH) && !q_full;

   assign push_data.err  = err_ff;
   assign push_data.thou = thou_ff;
   assign push_data.hund = hund_ff;
   assign push_data.tens = tens_ff;
   assign push_data.ones = ones_ff;

   // Classify on accept, then peel one decimal digit per cycle
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      err_in   = err_ff;
      thou_in  = thou_ff;
      hund_in  = hund_ff;
      tens_in  = tens_ff;
      ones_in  = ones_ff;
      dig      = 4'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dig      = digit_of(req_year, 12'd1000);
               err_in   = (req_year < lo_eff) || (req_year > hi_eff);
               thou_in  = dig[1:0];
               rem_in   = req_year - scale(dig, 12'd1000);
               state_in = S_HUND;
            end
         end
         S_HUND: begin
            dig      = digit_of(rem_ff, 12'd100);
            hund_in  = dig;
            rem_in   = rem_ff - scale(dig, 12'd100);
            state_in = S_TENS;
         end
         S_TENS: begin
            dig      = digit_of(rem_ff, 12'd10);
            tens_in  = dig;
            rem_in   = rem_ff - scale(dig, 12'd10);
            ones_in  = rem_in[3:0];
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (!q_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      err_ff  <= err_in;
      thou_ff <= thou_in;
      hund_ff <= hund_in;
      tens_ff <= tens_in;
      ones_ff <= ones_in;
   end

   // A beat is taken only in idle
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_HUND))
      else $error("accepted beat did not start conversion");

endmodule

@@ src/rne_queue.sv @@
module rne_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rne_pkg::entry_type      push_data,
   output logic                    full,
   input  logic                    pop,
   output rne_pkg::entry_type      pop_data,
   output logic                    empty
);

   rne_pkg::entry_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue occupancy overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

@@ src/rne_back.sv @@
module rne_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  rne_pkg::entry_type      q_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_symbol,
   output logic                    rsp_out_of_range,
   output logic                    rsp_last_symbol
);

   localparam logic [7:0] SYM_NONE = 8'h00;
   localparam logic [7:0] SYM_M    = 8'h4D;
   localparam logic [7:0] SYM_D    = 8'h44;
   localparam logic [7:0] SYM_C    = 8'h43;
   localparam logic [7:0] SYM_L    = 8'h4C;
   localparam logic [7:0] SYM_X    = 8'h58;
   localparam logic [7:0] SYM_V    = 8'h56;
   localparam logic [7:0] SYM_I    = 8'h49;

   logic        active_ff, active_in;
   logic        err_ff, err_in;
   logic [3:0]  d_ff [4];
   logic [3:0]  d_in [4];
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  j_ff, j_in;

   logic        valid_ff, valid_in;
   logic [7:0]  symbol_ff, symbol_in;
   logic        oor_ff, oor_in;
   logic        last_ff, last_in;

   logic [3:0]  cur_d;
   logic [2:0]  len;
   logic        digit_done;
   logic [3:0]  nz;
   logic [3:0]  later;
   logic        any_later;
   logic [1:0]  next_pos;
   logic [3:0]  new_nz;
   logic [1:0]  first_pos;
   logic        out_free;
   logic        emit;
   logic        is_last;
   logic [7:0]  one_sym, five_sym, ten_sym;
   logic [7:0]  pat_sym;

   // Letters emitted for one decimal digit
   function automatic logic [2:0] seq_len(input logic [3:0] d);
      logic [2:0] n;
      unique case (d) inside
         4'd1, 4'd5:                n = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9:    n = 3'd2;
         4'd3, 4'd7:                n = 3'd3;
         4'd8:                      n = 3'd4;
         default:                   n = 3'd0;
      endcase
      return n;
   endfunction

   // Current digit and its letter run
   assign cur_d      = d_ff[pos_ff];
   assign len        = seq_len(cur_d);
   assign digit_done = ({1'b0, j_ff} == (len - 3'd1));

   // Find the next place with letters
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         nz[i]     = (d_ff[i] != 4'd0);
         later[i]  = nz[i] && (2'(i) > pos_ff);
         new_nz[i] = (d_in[i] != 4'd0);
      end
      next_pos = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (later[i]) begin
            next_pos = 2'(i);
         end
      end
      first_pos = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (new_nz[i]) begin
            first_pos = 2'(i);
         end
      end
   end
   assign any_later = |later;

   // Letters of the current place
   always_comb begin
      unique case (pos_ff)
         2'd0:    begin one_sym = SYM_M; five_sym = SYM_NONE; ten_sym = SYM_NONE; end
         2'd1:    begin one_sym = SYM_C; five_sym = SYM_D;    ten_sym = SYM_M;    end
         2'd2:    begin one_sym = SYM_X; five_sym = SYM_L;    ten_sym = SYM_C;    end
         default: begin one_sym = SYM_I; five_sym = SYM_V;    ten_sym = SYM_X;    end
      endcase
   end

   // Pick the letter at this step of the digit
   always_comb begin
      if (cur_d == 4'd9) begin
         pat_sym = (j_ff == 2'd0) ? one_sym : ten_sym;
      end else if (cur_d == 4'd4) begin
         pat_sym = (j_ff == 2'd0) ? one_sym : five_sym;
      end else if (cur_d >= 4'd5) begin
         pat_sym = (j_ff == 2'd0) ? five_sym : one_sym;
      end else begin
         pat_sym = one_sym;
      end
   end

   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = active_ff && out_free;
   assign is_last  = err_ff || (digit_done && !any_later);
   assign pop      = !q_empty && (!active_ff || (emit && is_last));

   // Load digits on pop
   always_comb begin
      d_in[0] = pop ? {2'b00, q_data.thou} : d_ff[0];
      d_in[1] = pop ? q_data.hund : d_ff[1];
      d_in[2] = pop ? q_data.tens : d_ff[2];
      d_in[3] = pop ? q_data.ones : d_ff[3];
      err_in  = pop ? q_data.err : err_ff;
   end

   // Step through the run and fill the output register
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      j_in      = j_ff;
      valid_in  = valid_ff;
      symbol_in = symbol_ff;
      oor_in    = oor_ff;
      last_in   = last_ff;
      if (emit) begin
         valid_in  = 1'b1;
         symbol_in = err_ff ? SYM_NONE : pat_sym;
         oor_in    = err_ff;
         last_in   = is_last;
         if (is_last) begin
            active_in = 1'b0;
         end else if (digit_done) begin
            pos_in = next_pos;
            j_in   = 2'd0;
         end else begin
            j_in = j_ff + 2'd1;
         end
      end else if (out_free) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         active_in = 1'b1;
         pos_in    = first_pos;
         j_in      = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      pos_ff    <= pos_in;
      j_ff      <= j_in;
      symbol_ff <= symbol_in;
      oor_ff    <= oor_in;
      last_ff   <= last_in;
      for (int i = 0; i < 4; i++) begin
         d_ff[i] <= d_in[i];
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_symbol       = symbol_ff;
   assign rsp_out_of_range = oor_ff;
   assign rsp_last_symbol  = last_ff;

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && oor_ff) |-> (last_ff && (symbol_ff == SYM_NONE)))
      else $error("error beat is not a lone zero symbol");

   a_cur_nonzero: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !err_ff) |-> (cur_d != 4'd0))
      else $error("sequencer parked on an empty place");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> active_ff)
      else $error("popped entry not started");

endmodule

@@ src/roman_numeral_encoder.sv @@
// Flow: a year passes through the front states accept, hundreds, tens and push,
//   then passes through the queue to the back, which registers its first letter.
// Throughput: the back emits one letter per cycle while rsp_stall is low (1 to 15
//   per year); the front takes no new year until the last one has been pushed.
// Reset: synchronous; bounds return to 1000 and 3000, queue and output empty.
module roman_numeral_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_year,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_out_of_range,
   output logic        rsp_last_symbol,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   logic [11:0]        lowest_ff, lowest_in;
   logic [11:0]        highest_ff, highest_in;

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   rne_pkg::entry_type q_in_data;
   rne_pkg::entry_type q_out_data;

   // Bound registers
   always_comb begin
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      if (csr_we) begin
         case (csr_index)
            rne_pkg::CSR_LOWEST:  lowest_in  = csr_wdata;
            rne_pkg::CSR_HIGHEST: highest_in = csr_wdata;
            default:              lowest_in  = lowest_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff  <= rne_pkg::LOWEST_RESET;
         highest_ff <= rne_pkg::HIGHEST_RESET;
      end else begin
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
      end
   end

   rne_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_year     (req_year),
      .lowest_year  (lowest_ff),
      .highest_year (highest_ff),
      .push         (q_push),
      .push_data    (q_in_data),
      .q_full       (q_full)
   );

   rne_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   rne_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_out_data),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_last_symbol  (rsp_last_symbol)
   );

endmodule
